FILE: hdl/crt_pkg.sv
// Shared types, codes and microcode ROM for the connection reference-count table.
// Used by crt_seq, crt_datapath, the top level and the checker.
`timescale 1ns / 1ps

package crt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int ID_W    = 16;
  localparam int COUNT_W = 16;
  localparam int USED_W  = 5;
  localparam int STAT_W  = 3;
  localparam int UPC_W   = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [STAT_W-1:0] ST_INCREMENTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_DECREMENTED = 3'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL        = 3'd5;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] source_id;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] ref_count;
    logic [USED_W-1:0]  entries_used;
  } rsp_t;

  typedef logic [UPC_W-1:0] upc_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_IDX_EQ_USED,
    C_ID_NE,
    C_MODE_REM,
    C_CNT_GT1,
    C_NOT_FULL
  } cond_t;

  // when the word's op and emit take effect
  typedef enum logic [1:0] {
    G_ALWAYS,
    G_TAKEN,
    G_NOT_TAKEN
  } gate_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,     // capture request, clear index
    OP_READ,      // registered read at index
    OP_IDX_INC,
    OP_INC_CNT,   // saturating count + 1 at index
    OP_DEC_CNT,   // count - 1 at index
    OP_MOVE,      // copy read entry to index - 1, index + 1
    OP_APPEND,    // new entry at end, count one
    OP_USED_DEC
  } op_t;

  typedef struct packed {
    cond_t             cond;
    gate_t             gate;
    op_t               op;
    logic              emit;
    logic [STAT_W-1:0] status;
    upc_t              target;
  } uword_t;

  // control handed to the datapath, gating already applied
  typedef struct packed {
    op_t               op;
    logic              emit;
    logic [STAT_W-1:0] status;
  } ctrl_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic idx_eq_used;
    logic id_ne;
    logic mode_rem;
    logic cnt_gt1;
    logic not_full;
  } flags_t;

  localparam upc_t UA_IDLE      = 4'd0;
  localparam upc_t UA_SCAN      = 4'd1;
  localparam upc_t UA_CMP       = 4'd2;
  localparam upc_t UA_FOUND     = 4'd3;
  localparam upc_t UA_ADD_HIT   = 4'd4;
  localparam upc_t UA_REM_HIT   = 4'd5;
  localparam upc_t UA_REM_STEP  = 4'd6;
  localparam upc_t UA_SHIFT_CHK = 4'd7;
  localparam upc_t UA_SHIFT_MV  = 4'd8;
  localparam upc_t UA_REM_DONE  = 4'd9;
  localparam upc_t UA_MISS      = 4'd10;
  localparam upc_t UA_ADD_MISS  = 4'd11;
  localparam upc_t UA_FULL      = 4'd12;
  localparam upc_t UA_NOT_FOUND = 4'd13;

  function automatic uword_t uw(cond_t c, gate_t g, op_t o, logic e,
                                logic [STAT_W-1:0] s, upc_t t);
    uword_t w;
    w.cond   = c;
    w.gate   = g;
    w.op     = o;
    w.emit   = e;
    w.status = s;
    w.target = t;
    return w;
  endfunction

  // Program: a taken condition jumps to target, otherwise fall through.
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    case (a)
      UA_IDLE:      w = uw(C_NO_START, G_NOT_TAKEN, OP_LATCH, 1'b0, ST_INCREMENTED, UA_IDLE);
      UA_SCAN:      w = uw(C_IDX_EQ_USED, G_ALWAYS, OP_READ, 1'b0, ST_INCREMENTED, UA_MISS);
      UA_CMP:       w = uw(C_ID_NE, G_TAKEN, OP_IDX_INC, 1'b0, ST_INCREMENTED, UA_SCAN);
      UA_FOUND:     w = uw(C_MODE_REM, G_ALWAYS, OP_NONE, 1'b0, ST_INCREMENTED, UA_REM_HIT);
      UA_ADD_HIT:   w = uw(C_ALWAYS, G_ALWAYS, OP_INC_CNT, 1'b1, ST_INCREMENTED, UA_IDLE);
      UA_REM_HIT:   w = uw(C_CNT_GT1, G_TAKEN, OP_DEC_CNT, 1'b1, ST_DECREMENTED, UA_IDLE);
      UA_REM_STEP:  w = uw(C_NEVER, G_ALWAYS, OP_IDX_INC, 1'b0, ST_INCREMENTED, UA_IDLE);
      UA_SHIFT_CHK: w = uw(C_IDX_EQ_USED, G_ALWAYS, OP_READ, 1'b0, ST_INCREMENTED, UA_REM_DONE);
      UA_SHIFT_MV:  w = uw(C_ALWAYS, G_ALWAYS, OP_MOVE, 1'b0, ST_INCREMENTED, UA_SHIFT_CHK);
      UA_REM_DONE:  w = uw(C_ALWAYS, G_ALWAYS, OP_USED_DEC, 1'b1, ST_REMOVED, UA_IDLE);
      UA_MISS:      w = uw(C_MODE_REM, G_ALWAYS, OP_NONE, 1'b0, ST_INCREMENTED, UA_NOT_FOUND);
      UA_ADD_MISS:  w = uw(C_NOT_FULL, G_TAKEN, OP_APPEND, 1'b1, ST_INSERTED, UA_IDLE);
      UA_FULL:      w = uw(C_ALWAYS, G_ALWAYS, OP_NONE, 1'b1, ST_FULL, UA_IDLE);
      UA_NOT_FOUND: w = uw(C_ALWAYS, G_ALWAYS, OP_NONE, 1'b1, ST_NOT_FOUND, UA_IDLE);
      default:      w = uw(C_ALWAYS, G_ALWAYS, OP_NONE, 1'b0, ST_INCREMENTED, UA_IDLE);
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/crt_seq.sv
// Microcode sequencer: step counter, ROM lookup, conditional jumps.
// Depends on crt_pkg for the control word, ROM and flag structs.
`timescale 1ns / 1ps

module crt_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  crt_pkg::flags_t flags,
  output crt_pkg::ctrl_t  ctrl,
  output logic            busy
);

  crt_pkg::upc_t   upc;
  crt_pkg::upc_t   upc_next;
  crt_pkg::uword_t word;
  logic            taken;
  logic            active;

  assign word = crt_pkg::ucode(upc);

  always_comb begin
    case (word.cond)
      crt_pkg::C_NEVER:       taken = 1'b0;
      crt_pkg::C_ALWAYS:      taken = 1'b1;
      crt_pkg::C_NO_START:    taken = !start;
      crt_pkg::C_IDX_EQ_USED: taken = flags.idx_eq_used;
      crt_pkg::C_ID_NE:       taken = flags.id_ne;
      crt_pkg::C_MODE_REM:    taken = flags.mode_rem;
      crt_pkg::C_CNT_GT1:     taken = flags.cnt_gt1;
      crt_pkg::C_NOT_FULL:    taken = flags.not_full;
      default:                taken = 1'b0;
    endcase
  end

  always_comb begin
    case (word.gate)
      crt_pkg::G_ALWAYS:    active = 1'b1;
      crt_pkg::G_TAKEN:     active = taken;
      crt_pkg::G_NOT_TAKEN: active = !taken;
      default:              active = 1'b0;
    endcase
  end

  assign upc_next    = taken ? word.target : upc + 1'b1;
  assign ctrl.op     = active ? word.op : crt_pkg::OP_NONE;
  assign ctrl.emit   = active & word.emit;
  assign ctrl.status = word.status;
  assign busy        = (upc != crt_pkg::UA_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= crt_pkg::UA_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

FILE: hdl/crt_datapath.sv
// Datapath: id/count memories, index and occupancy registers, result register.
// Depends on crt_pkg; driven by crt_seq through ctrl_t.
`timescale 1ns / 1ps

module crt_datapath #(
  parameter int TABLE_DEPTH = crt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  crt_pkg::req_t   req,
  input  crt_pkg::ctrl_t  ctrl,
  output crt_pkg::flags_t flags,
  output logic            done,
  output crt_pkg::rsp_t   rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = $clog2(TABLE_DEPTH + 1);

  logic [crt_pkg::ID_W-1:0]    ids  [TABLE_DEPTH];
  logic [crt_pkg::COUNT_W-1:0] cnts [TABLE_DEPTH];

  crt_pkg::req_t               req_r;
  logic [IW-1:0]               idx;
  logic [IW-1:0]               idx_next;
  logic [IW-1:0]               used;
  logic [IW-1:0]               used_next;
  logic [crt_pkg::ID_W-1:0]    rd_id;
  logic [crt_pkg::COUNT_W-1:0] rd_cnt;

  logic                        wr_id_en;
  logic                        wr_cnt_en;
  logic [AW-1:0]               wr_addr;
  logic [crt_pkg::ID_W-1:0]    wr_id;
  logic [crt_pkg::COUNT_W-1:0] wr_cnt;
  logic [crt_pkg::COUNT_W-1:0] cnt_sat;
  logic [crt_pkg::COUNT_W-1:0] res_cnt;

  assign cnt_sat = (rd_cnt == crt_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

  always_comb begin
    wr_id_en  = 1'b0;
    wr_cnt_en = 1'b0;
    wr_addr   = idx[AW-1:0];
    wr_id     = rd_id;
    wr_cnt    = rd_cnt;
    idx_next  = idx;
    used_next = used;
    res_cnt   = '0;
    case (ctrl.op)
      crt_pkg::OP_LATCH: begin
        idx_next = '0;
      end
      crt_pkg::OP_IDX_INC: begin
        idx_next = idx + 1'b1;
      end
      crt_pkg::OP_INC_CNT: begin
        wr_cnt_en = 1'b1;
        wr_cnt    = cnt_sat;
        res_cnt   = cnt_sat;
      end
      crt_pkg::OP_DEC_CNT: begin
        wr_cnt_en = 1'b1;
        wr_cnt    = rd_cnt - 1'b1;
        res_cnt   = rd_cnt - 1'b1;
      end
      crt_pkg::OP_MOVE: begin
        // compaction: entry read at idx slides down one place
        wr_id_en  = 1'b1;
        wr_cnt_en = 1'b1;
        wr_addr   = AW'(idx - 1'b1);
        idx_next  = idx + 1'b1;
      end
      crt_pkg::OP_APPEND: begin
        wr_id_en  = 1'b1;
        wr_cnt_en = 1'b1;
        wr_addr   = used[AW-1:0];
        wr_id     = req_r.source_id;
        wr_cnt    = crt_pkg::COUNT_W'(1);
        used_next = used + 1'b1;
        res_cnt   = crt_pkg::COUNT_W'(1);
      end
      crt_pkg::OP_USED_DEC: begin
        used_next = used - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_id_en) begin
      ids[wr_addr] <= wr_id;
    end
    if (wr_cnt_en) begin
      cnts[wr_addr] <= wr_cnt;
    end
    if (ctrl.op == crt_pkg::OP_READ) begin
      rd_id  <= ids[idx[AW-1:0]];
      rd_cnt <= cnts[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == crt_pkg::OP_LATCH) begin
      req_r <= req;
    end
    if (ctrl.emit) begin
      rsp.status       <= ctrl.status;
      rsp.ref_count    <= res_cnt;
      rsp.entries_used <= crt_pkg::USED_W'(used_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      used <= '0;
      done <= 1'b0;
    end else begin
      idx  <= idx_next;
      used <= used_next;
      done <= ctrl.emit;
    end
  end

  assign flags.idx_eq_used = (idx == used);
  assign flags.id_ne       = (rd_id != req_r.source_id);
  assign flags.mode_rem    = (req_r.mode == crt_pkg::MODE_REMOVE);
  assign flags.cnt_gt1     = (rd_cnt > crt_pkg::COUNT_W'(1));
  assign flags.not_full    = (used != IW'(TABLE_DEPTH));

endmodule

FILE: hdl/connection_refcount_table_unit.sv
// Connection reference-count table: an ordered table of source ids with
// reference counts. A request is taken when start is high and busy low; one
// result word follows, shown for a single cycle with done high, and the
// receiver cannot stall it. The request is worked by a microcode sequencer
// over one table memory port: the search reads and then compares each entry
// passed, and a removal that deletes an entry reads and then moves each later
// entry down one place; busy drops when done rises.
// Depends on crt_pkg, crt_seq and crt_datapath.
`timescale 1ns / 1ps

module connection_refcount_table_unit #(
  parameter int TABLE_DEPTH = crt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  crt_pkg::req_t req,
  output logic          done,
  output crt_pkg::rsp_t rsp
);

  crt_pkg::ctrl_t  ctrl;
  crt_pkg::flags_t flags;

  crt_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  crt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .ctrl  (ctrl),
    .flags (flags),
    .done  (done),
    .rsp   (rsp)
  );

endmodule

FILE: hdl/crt_checker.sv
// Port-level checks for connection_refcount_table_unit, bound to the top level.
// Depends on crt_pkg for status codes.
`timescale 1ns / 1ps

module crt_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input crt_pkg::rsp_t rsp
);

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // a result only closes a request that was in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result without a request in progress");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.status <= crt_pkg::ST_FULL)
    else $error("illegal status code");

  a_insert_one: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == crt_pkg::ST_INSERTED |-> rsp.ref_count == 16'd1)
    else $error("insert must report count one");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status == crt_pkg::ST_REMOVED || rsp.status == crt_pkg::ST_NOT_FOUND
             || rsp.status == crt_pkg::ST_FULL) |-> rsp.ref_count == 16'd0)
    else $error("absent entry must report count zero");

endmodule

bind connection_refcount_table_unit crt_checker u_crt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
